/* rtl/core/a2e_pkg.sv */
// Shared types and constants for the ASN.1 time string to epoch seconds converter.
// Used by the parser, the record queue, the converter and the top level.
package a2e_pkg;

  localparam int unsigned EpochW = 39;
  localparam int unsigned OutTdataW = 48;

  // Parse phases. Values below PH_SEC1 count the characters of the date and time digits.
  localparam logic [4:0] PH_SEC1 = 5'd16;
  localparam logic [4:0] PH_SEC2 = 5'd17;
  localparam logic [4:0] PH_REST = 5'd18;
  localparam logic [4:0] PH_OH1  = 5'd19;
  localparam logic [4:0] PH_OH2  = 5'd20;
  localparam logic [4:0] PH_OM1  = 5'd21;
  localparam logic [4:0] PH_OM2  = 5'd22;
  localparam logic [4:0] PH_DONE = 5'd23;

  localparam logic [1:0] KIND_GEN = 2'd1;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_RANGE  = 2'd2,
    ERR_LOCAL  = 2'd3
  } err_code_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DIV,
    CS_DAYS,
    CS_TOT,
    CS_MUL,
    CS_DONE
  } conv_state_e;

  // One parsed time string handed from the parser to the converter.
  typedef struct packed {
    err_code_e   pre_code;  // nonzero: result is settled, no arithmetic needed
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        zone_neg;
    logic [9:0]  zone_min;
  } a2e_rec_t;

  // Days before the first of each month in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/asn1_time_to_epoch_seconds.sv */
// ASN.1 UTCTime / GeneralizedTime string to seconds since 1970, top level.
// Depends on a2e_pkg, a2e_parse, a2e_fifo and a2e_conv.
//
// Input stream: one beat per character. s_axis_tdata is the character, s_axis_tuser the
// string kind (sampled on the first beat of a string), s_axis_tlast marks the final beat.
// Output stream: one beat per string, sent after its last character. m_axis_tdata holds
// the signed seconds (0 on error) and the error code.
// Characters are taken one per cycle while the queue is not full. The parser hands each
// finished string to a two-entry queue, and the converter works through it in one pass
// of its step sequencer (divide, days, total, multiply, done); the result beat goes
// valid when the done step loads the output register. A well-formed string is at least
// eleven characters, so the converter keeps pace with the character rate; a run of very
// short, malformed strings can fill the queue and stall the input. The queue also fills
// when the receiver holds m_axis_tready low and results back up.
// A result waits in the output register for as long as the receiver stalls.
// Reset clears the parser, the queue and the converter; no clearing pass is needed and
// the block takes characters as soon as reset is released.
module asn1_time_to_epoch_seconds import a2e_pkg::*; #(
  parameter int unsigned NARROW_TIME = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]           s_axis_tuser,   // [1:0] time_kind
  input  logic                 s_axis_tlast,   // last_char
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [38:0] epoch_seconds, [40:39] error_code
);

  logic              accept, push, full, rec_valid, pop;
  a2e_rec_t          rec_in, rec_out;
  logic [EpochW-1:0] epoch;
  err_code_e         code;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  a2e_parse u_parse (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .kind_i   (s_axis_tuser),
    .char_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  a2e_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (rec_valid),
    .rec_o   (rec_out)
  );

  a2e_conv #(
    .NARROW_TIME (NARROW_TIME)
  ) u_conv (
    .clk_i,
    .rst_ni,
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .epoch_o     (epoch),
    .code_o      (code)
  );

  assign m_axis_tdata = {(OutTdataW - EpochW - 2)'(0), code, epoch};

endmodule

/* rtl/core/a2e_parse.sv */
// Character parser: walks the time string one beat at a time and builds a record.
// Depends on a2e_pkg; pushes one record into the queue on the last beat.
module a2e_parse import a2e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       push_o,
  output a2e_rec_t   rec_o
);

  localparam logic [2:0] FLD_YEAR  = 3'd0;
  localparam logic [2:0] FLD_MONTH = 3'd1;
  localparam logic [2:0] FLD_DAY   = 3'd2;
  localparam logic [2:0] FLD_HOUR  = 3'd3;

  logic [4:0]  pos_q, pos_d;
  logic [13:0] acc_q, acc_d;
  logic [1:0]  kind_q, kind_d;
  logic        started_q;
  logic [13:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [9:0]  zo_q, zo_d;
  logic        zneg_q, zneg_d;
  logic        err_q, err_d;

  logic        gen, dig, zone_go, zone_skip;
  logic [3:0]  dig_val;
  logic [4:0]  off, rel;
  logic [17:0] acc_mul;
  logic [13:0] acc_new;
  logic [7:0]  v2;

  assign kind_d  = started_q ? kind_q : kind_i;
  assign gen     = (kind_d == KIND_GEN);
  assign off     = gen ? 5'd2 : 5'd0;
  assign rel     = pos_q - off;
  assign dig     = (char_i >= CH_0) && (char_i <= CH_9);
  assign dig_val = dig ? char_i[3:0] : 4'd0;
  assign acc_mul = 18'(acc_q) * 18'd10 + 18'(dig_val);
  assign acc_new = acc_mul[13:0];
  // Second digit of a two-digit field; the accumulator holds only the first digit here.
  assign v2      = 8'(acc_q[3:0]) * 8'd10 + 8'(dig_val);
  // GeneralizedTime lets fractional seconds through before the zone.
  assign zone_skip = gen && ((char_i == CH_DOT) || (char_i == CH_COMMA) || dig);

  always_comb begin
    pos_d   = pos_q;
    acc_d   = acc_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    zo_d    = zo_q;
    zneg_d  = zneg_q;
    err_d   = err_q;
    zone_go = 1'b0;
    if (!err_q) begin
      if (pos_q < PH_SEC1) begin
        if (!dig) begin
          err_d = 1'b1;
        end else begin
          acc_d = acc_new;
          if ((pos_q >= off + 5'd1) && rel[0]) begin
            acc_d = '0;
            case (rel[3:1])
              FLD_YEAR: begin
                if (gen) year_d = acc_new;
                else if (acc_new < 14'd50) year_d = acc_new + 14'd2000;
                else year_d = acc_new + 14'd1900;
              end
              FLD_MONTH: begin
                if (acc_new < 14'd1 || acc_new > 14'd12) err_d = 1'b1;
                else month_d = acc_new[3:0];
              end
              FLD_DAY: begin
                if (acc_new < 14'd1 || acc_new > 14'd31) err_d = 1'b1;
                else day_d = acc_new[4:0];
              end
              FLD_HOUR: begin
                if (acc_new > 14'd23) err_d = 1'b1;
                else hour_d = acc_new[4:0];
              end
              default: begin
                if (acc_new > 14'd59) err_d = 1'b1;
                else min_d = acc_new[5:0];
              end
            endcase
          end
          pos_d = (pos_q == off + 5'd9) ? PH_SEC1 : pos_q + 5'd1;
        end
      end else begin
        case (pos_q)
          PH_SEC1: begin
            if (dig) begin
              acc_d = 14'(dig_val);
              pos_d = PH_SEC2;
            end else begin
              sec_d   = '0;
              pos_d   = PH_REST;
              zone_go = 1'b1;
            end
          end
          PH_SEC2: begin
            acc_d = '0;
            if (!dig || v2 > 8'd59) begin
              err_d = 1'b1;
            end else begin
              sec_d = v2[5:0];
              pos_d = PH_REST;
            end
          end
          PH_REST: zone_go = 1'b1;
          PH_OH1, PH_OM1: begin
            if (!dig) begin
              err_d = 1'b1;
            end else begin
              acc_d = 14'(dig_val);
              pos_d = pos_q + 5'd1;
            end
          end
          PH_OH2: begin
            acc_d = '0;
            if (!dig || v2 > 8'd12) begin
              err_d = 1'b1;
            end else begin
              zo_d  = 10'(v2) * 10'd60;
              pos_d = PH_OM1;
            end
          end
          PH_OM2: begin
            acc_d = '0;
            if (!dig || v2 > 8'd59) begin
              err_d = 1'b1;
            end else begin
              zo_d  = zo_q + 10'(v2);
              pos_d = PH_DONE;
            end
          end
          default: err_d = 1'b1;
        endcase
        if (zone_go && !zone_skip) begin
          if (char_i == CH_Z) begin
            zo_d   = '0;
            zneg_d = 1'b0;
            pos_d  = PH_DONE;
          end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
            zneg_d = (char_i == CH_MINUS);
            pos_d  = PH_OH1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    rec_o.year     = year_d;
    rec_o.month    = month_d;
    rec_o.day      = day_d;
    rec_o.hour     = hour_d;
    rec_o.minute   = min_d;
    rec_o.second   = sec_d;
    rec_o.zone_neg = zneg_d;
    rec_o.zone_min = zo_d;
    if (kind_d[1] || err_d) rec_o.pre_code = ERR_FORMAT;
    else if (pos_d == PH_SEC1 || pos_d == PH_REST) rec_o.pre_code = gen ? ERR_LOCAL : ERR_FORMAT;
    else if (pos_d != PH_DONE) rec_o.pre_code = ERR_FORMAT;
    else rec_o.pre_code = ERR_OK;
  end

  assign push_o = accept_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      acc_q     <= '0;
      kind_q    <= '0;
      started_q <= 1'b0;
      year_q    <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      zo_q      <= '0;
      zneg_q    <= 1'b0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        // The string is complete: start over for the next one.
        pos_q     <= '0;
        acc_q     <= '0;
        kind_q    <= '0;
        started_q <= 1'b0;
        year_q    <= '0;
        month_q   <= '0;
        day_q     <= '0;
        hour_q    <= '0;
        min_q     <= '0;
        sec_q     <= '0;
        zo_q      <= '0;
        zneg_q    <= 1'b0;
        err_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        acc_q     <= acc_d;
        kind_q    <= kind_d;
        started_q <= 1'b1;
        year_q    <= year_d;
        month_q   <= month_d;
        day_q     <= day_d;
        hour_q    <= hour_d;
        min_q     <= min_d;
        sec_q     <= sec_d;
        zo_q      <= zo_d;
        zneg_q    <= zneg_d;
        err_q     <= err_d;
      end
    end
  end

endmodule

/* rtl/core/a2e_fifo.sv */
// Two-entry record queue between the parser and the converter.
// Depends on a2e_pkg for the record type.
module a2e_fifo import a2e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  a2e_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output a2e_rec_t rec_o
);

  a2e_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* rtl/core/a2e_conv.sv */
// Converter: turns a parsed record into seconds since 1970 over a short sequence of steps.
// Depends on a2e_pkg; holds the result in an output register until it is taken.
module a2e_conv import a2e_pkg::*; #(
  parameter int unsigned NARROW_TIME = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  a2e_rec_t            rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [EpochW-1:0]   epoch_o,
  output err_code_e           code_o
);

  localparam bit Narrow = (NARROW_TIME != 0);

  conv_state_e state_q, state_d;
  logic        load_out;

  a2e_rec_t           r_q;
  logic [6:0]         q_q, q_d;
  logic signed [13:0] days_q, days_d;
  logic signed [23:0] ydays_q, ydays_d;
  logic signed [23:0] tot_q, tot_d;
  logic signed [18:0] hsec_q, hsec_d;
  logic signed [40:0] t_q, t_d;

  logic              out_valid_q;
  logic [EpochW-1:0] epoch_q;
  err_code_e         code_q, code_c;

  logic [26:0]        qprod;
  logic [13:0]        q100;
  logic [6:0]         rem;
  logic               y_ge, leap, leapadj;
  logic [3:0]         mi;
  logic [7:0]         k, m;
  logic signed [8:0]  cent_hi, cent_lo;
  logic [13:0]        lp_hi, lp_lo;
  logic signed [12:0] corr;
  logic signed [14:0] yd;
  logic signed [10:0] zo_s;
  logic signed [11:0] mdiff;

  // Year divided by 100 through a reciprocal multiply, exact for years below 12800 (the quotient is held in 7 bits).
  assign qprod = 27'(r_q.year) * 27'd5243;
  assign q_d   = qprod[25:19];

  assign q100    = 14'(q_q) * 14'd100;
  assign rem     = 7'(r_q.year - q100);
  assign y_ge    = (r_q.year >= 14'd1970);
  assign leap    = ((r_q.year[1:0] == 2'd0) && (rem != 7'd0))
                 || ((rem == 7'd0) && (q_q[1:0] == 2'd0));
  assign mi      = (r_q.month == 4'd0) ? 4'd0 : r_q.month - 4'd1;
  assign leapadj = leap && (mi >= 4'd2);

  // Century years skipped as leap years between the year and the epoch.
  assign k       = (rem == 7'd0) ? 8'(q_q) - 8'd1 : 8'(q_q);
  assign m       = (rem == 7'd0) ? 8'(q_q) : 8'(q_q) + 8'd1;
  assign cent_hi = $signed({1'b0, k}) - $signed({3'b0, k[7:2]}) - 9'sd15;
  assign cent_lo = (r_q.year == 14'd0) ? 9'sd15
                 : 9'sd16 - $signed({1'b0, m}) + $signed({3'b0, 6'((m - 8'd1) >> 2)});
  assign lp_hi   = (r_q.year - 14'd1969) >> 2;
  assign lp_lo   = (14'd1972 - r_q.year) >> 2;

  always_comb begin
    if (y_ge) begin
      corr = $signed({1'b0, 12'(lp_hi)}) - (Narrow ? 13'sd0 : 13'(cent_hi));
    end else begin
      corr = (Narrow ? 13'sd0 : 13'(cent_lo)) - $signed({1'b0, 12'(lp_lo)});
    end
  end

  assign days_d = 14'($signed({1'b0, r_q.day}) - 6'sd1)
                + $signed({5'b0, cum_days(mi)})
                + $signed({13'b0, leapadj})
                + 14'(corr);
  assign yd      = $signed({1'b0, r_q.year}) - 15'sd1970;
  assign ydays_d = 24'(yd) * 24'sd365;

  assign tot_d  = ydays_q + 24'(days_q);
  assign zo_s   = r_q.zone_neg ? -$signed({1'b0, r_q.zone_min}) : $signed({1'b0, r_q.zone_min});
  assign mdiff  = $signed({6'b0, r_q.minute}) - 12'(zo_s);
  assign hsec_d = $signed({2'b0, 17'(r_q.hour) * 17'd3600})
                + 19'(mdiff) * 19'sd60
                + $signed({13'b0, r_q.second});

  assign t_d = 41'(tot_q) * 41'sd86400 + 41'(hsec_q);

  always_comb begin
    code_c = ERR_OK;
    if (r_q.pre_code != ERR_OK) begin
      code_c = r_q.pre_code;
    end else begin
      if (Narrow && (r_q.year < 14'd1900 || r_q.year > 14'd2040)) code_c = ERR_RANGE;
      // The sign of the result must agree with the side of the epoch the year is on.
      if (y_ge && t_q < 41'sd0) code_c = ERR_RANGE;
      if (!y_ge && t_q >= 41'sd0) code_c = ERR_RANGE;
      if (Narrow && (t_q < -41'sd2147483648 || t_q > 41'sd2147483647)) code_c = ERR_RANGE;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (rec_valid_i) begin
          pop_o   = 1'b1;
          state_d = CS_DIV;
        end
      end
      CS_DIV:  state_d = CS_DAYS;
      CS_DAYS: state_d = CS_TOT;
      CS_TOT:  state_d = CS_MUL;
      CS_MUL:  state_d = CS_DONE;
      CS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: if (rec_valid_i) r_q <= rec_i;
      CS_DIV:  q_q <= q_d;
      CS_DAYS: begin
        days_q  <= days_d;
        ydays_q <= ydays_d;
      end
      CS_TOT: begin
        tot_q  <= tot_d;
        hsec_q <= hsec_d;
      end
      CS_MUL:  t_q <= t_d;
      CS_DONE: begin
        if (load_out) begin
          code_q  <= code_c;
          epoch_q <= (code_c == ERR_OK) ? t_q[EpochW-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign epoch_o     = epoch_q;
  assign code_o      = code_q;

endmodule
